@@ rtl/core/dteq_pkg.sv @@
// Shared types and constants for the delta-time event queue.
package dteq_pkg;

  localparam int unsigned DeltaW = 31;
  localparam int unsigned TypeW  = 16;
  localparam logic [30:0] DefaultFrame = 31'd16666;
  localparam logic [30:0] DeltaMax     = 31'h7FFF_FFFF;

  typedef enum logic [2:0] {
    CMD_POST     = 3'd0,
    CMD_NEXT     = 3'd1,
    CMD_NEXT_HB  = 3'd2,
    CMD_FLUSH    = 3'd3,
    CMD_FLUSH_TY = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_DROPPED = 2'd2,
    ST_HBEAT   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    REG_CAPACITY = 2'd0,
    REG_HB_TYPE  = 2'd1,
    REG_FRAME    = 2'd2
  } reg_e;

  typedef struct packed {
    logic [2:0]  command;
    logic signed [15:0] event_type;
    logic [31:0] event_payload;
    logic [30:0] delay;
    logic        at_end;
  } in_beat_t;

  typedef struct packed {
    logic signed [15:0] out_type;
    logic [31:0] out_payload;
    logic [30:0] out_delta;
    logic [1:0]  status;
    logic [4:0]  occupancy;
    logic [4:0]  peak_fill;
    logic [31:0] drop_count;
    logic [31:0] empty_count;
    logic [31:0] hb_count;
  } out_beat_t;

  // Operation broadcast to every cell.
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_INSERT,
    OP_POP,
    OP_FLUSH
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    logic signed [15:0] ins_type;
    logic [31:0] ins_payload;
  } cell_ctl_t;

endpackage

@@ rtl/core/dteq_cell.sv @@
// One queue slot: holds an entry and shifts toward neighbors on insert, pop or compaction.
module dteq_cell #(
  parameter int unsigned PayloadW = 32
) (
  input  logic                  clk_i,
  input  dteq_pkg::cell_ctl_t   ctl_i,
  input  logic                  ins_here_i,   // new entry lands in this slot
  input  logic                  shift_up_i,   // take entry from previous slot
  input  logic                  fix_delta_i,  // subtract remaining from own delta
  input  logic                  flush_take_i, // flush step: take from next slot
  input  logic [30:0]           ins_delta_i,
  input  logic signed [15:0]    prev_type_i,
  input  logic [PayloadW-1:0]   prev_payload_i,
  input  logic [30:0]           prev_delta_i,
  input  logic signed [15:0]    next_type_i,
  input  logic [PayloadW-1:0]   next_payload_i,
  input  logic [30:0]           next_delta_i,
  input  logic [30:0]           flush_delta_i,
  output logic signed [15:0]    type_o,
  output logic [PayloadW-1:0]   payload_o,
  output logic [30:0]           delta_o
);
  import dteq_pkg::*;

  logic signed [15:0]  type_q, type_d;
  logic [PayloadW-1:0] payload_q, payload_d;
  logic [30:0]         delta_q, delta_d;

  always_comb begin
    type_d    = type_q;
    payload_d = payload_q;
    delta_d   = delta_q;
    unique case (ctl_i.op)
      OP_INSERT: begin
        if (ins_here_i) begin
          type_d    = ctl_i.ins_type;
          payload_d = PayloadW'(ctl_i.ins_payload);
          delta_d   = ins_delta_i;
        end else if (shift_up_i) begin
          type_d    = prev_type_i;
          payload_d = prev_payload_i;
          delta_d   = fix_delta_i ? prev_delta_i - ins_delta_i : prev_delta_i;
        end
      end
      OP_POP: begin
        type_d    = next_type_i;
        payload_d = next_payload_i;
        delta_d   = next_delta_i;
      end
      OP_FLUSH: begin
        if (flush_take_i) begin
          type_d    = next_type_i;
          payload_d = next_payload_i;
          delta_d   = flush_delta_i;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    type_q    <= type_d;
    payload_q <= payload_d;
    delta_q   <= delta_d;
  end

  assign type_o    = type_q;
  assign payload_o = payload_q;
  assign delta_o   = delta_q;

endmodule

@@ rtl/core/delta_time_event_queue_top.sv @@
// Top level of the delta-time event queue: control sequencer over a chain of slot cells.
// Sequence: a post walks the slots (S_WALK), inserts (S_INSERT) and reports (S_DONE); an
//   at-end post walks from the tail; flush by type scans the filled slots (S_FWALK);
//   dropped post, pop, flush all and unknown codes go straight to S_DONE. Throughput: one
//   beat in flight; the next input waits for S_IDLE and for the result to leave the output.
// Reset: queue empty, statistics zero, capacity DEPTH capped at 16, frame period 16666; slot contents
//   are not reset and are only read below the fill count.
module delta_time_event_queue_top #(
  parameter int unsigned DEPTH        = 16,
  parameter int unsigned PAYLOAD_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  dteq_pkg::in_beat_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output dteq_pkg::out_beat_t  out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [1:0]           cfg_index_i,
  input  logic [31:0]          cfg_data_i
);
  import dteq_pkg::*;

  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [CntW-1:0] DepthC = CntW'(DEPTH);

  typedef enum logic [2:0] {
    S_IDLE, S_WALK, S_INSERT, S_FWALK, S_DONE
  } state_e;

  state_e state_q;
  in_beat_t cmd_q;
  logic [CntW-1:0] count_q, peak_q, cap_q, pos_q;
  logic [31:0] drop_q, empty_q, recov_q;
  logic signed [15:0] hb_type_q;
  logic [30:0] frame_q, remain_q, carry_q;
  out_beat_t res_q;
  logic res_valid_q;
  out_beat_t res_init;   // data part of the result, fixed at accept
  out_beat_t res_fin;    // result with statistics filled in

  // cell chain wiring
  logic signed [15:0]      c_type [DEPTH];
  logic [PAYLOAD_BITS-1:0] c_pay [DEPTH];
  logic [30:0]             c_delta [DEPTH];
  cell_ctl_t ctl;
  logic [CntW-1:0] fpos;     // flush scan position: cells at and above it shift down
  logic flush_drop;
  logic [31:0] fold_sum;
  logic [30:0] fold_sat;

  // Flush by type scans slot pos_q: a match is removed by shifting the tail down,
  // and its delta folds into the entry that moves into its place.
  assign fold_sum = {1'b0, c_delta[pos_q[IdxW-1:0]]} + {1'b0, carry_q};
  assign fold_sat = fold_sum[31] ? DeltaMax : fold_sum[30:0];
  assign flush_drop = (c_type[pos_q[IdxW-1:0]] == cmd_q.event_type);
  assign fpos = pos_q;

  // At-end posts start the walk at the tail, so they stop at once.
  logic walk_stop;
  assign walk_stop = (pos_q >= count_q) || cmd_q.at_end ||
                     (remain_q < c_delta[pos_q[IdxW-1:0]]);

  always_comb begin
    ctl.op          = OP_HOLD;
    ctl.ins_type    = cmd_q.event_type;
    ctl.ins_payload = cmd_q.event_payload;
    if (state_q == S_INSERT) ctl.op = OP_INSERT;
    if (state_q == S_FWALK && pos_q < count_q && flush_drop) ctl.op = OP_FLUSH;
    if (state_q == S_IDLE && in_valid_i && !in_stall_o &&
        (in_data_i.command == CMD_NEXT || in_data_i.command == CMD_NEXT_HB) &&
        count_q != '0) ctl.op = OP_POP;
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    localparam int Pv = (g == 0) ? 0 : g - 1;
    localparam int Nx = (g == DEPTH - 1) ? g : g + 1;
    logic [CntW-1:0] gi;
    logic [30:0] fd;
    assign gi = CntW'(g);
    // folded delta goes to the entry landing in the removed slot only
    assign fd = (gi == fpos) ? (Nx == g ? c_delta[g] :
                ((32'({1'b0, c_delta[Nx]}) + 32'({1'b0, fold_sat})) > 32'(DeltaMax) ?
                 DeltaMax : c_delta[Nx] + fold_sat)) : c_delta[Nx];
    dteq_cell #(.PayloadW(PAYLOAD_BITS)) u_cell (
      .clk_i,
      .ctl_i          (ctl),
      .ins_here_i     (gi == pos_q),
      .shift_up_i     (gi > pos_q && gi <= count_q),
      .fix_delta_i    (gi == pos_q + CntW'(1) && !cmd_q.at_end),
      .flush_take_i   (gi >= fpos),
      .ins_delta_i    (cmd_q.at_end ? '0 : remain_q),
      .prev_type_i    (c_type[Pv]),
      .prev_payload_i (c_pay[Pv]),
      .prev_delta_i   (c_delta[Pv]),
      .next_type_i    (c_type[Nx]),
      .next_payload_i (c_pay[Nx]),
      .next_delta_i   (c_delta[Nx]),
      .flush_delta_i  (fd),
      .type_o         (c_type[g]),
      .payload_o      (c_pay[g]),
      .delta_o        (c_delta[g])
    );
  end

  // Fold into follower: when the removed entry has a follower it absorbs fold_sat;
  // when it was last, carry is dropped (matches the model, which discards it).

  // A pending register write holds the input off so the two never share an edge.
  assign in_stall_o  = (state_q != S_IDLE) || res_valid_q || cfg_valid_i;
  assign cfg_ready_o = (state_q == S_IDLE) && !res_valid_q;
  assign out_valid_o = res_valid_q;
  assign out_data_o  = res_q;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    sat_inc = (v == '1) ? v : v + 32'd1;
  endfunction

  logic [4:0] cap_w;
  assign cap_w = cfg_data_i[4:0];

  // Data fields of the result as seen at the accepting edge.
  always_comb begin
    res_init = '0;
    res_init.status = ST_OK;
    if (in_data_i.command == CMD_POST) begin
      if (count_q >= cap_q) res_init.status = ST_DROPPED;
    end else if (in_data_i.command == CMD_NEXT || in_data_i.command == CMD_NEXT_HB) begin
      if (count_q != '0) begin
        res_init.out_type    = c_type[0];
        res_init.out_payload = 32'(c_pay[0]);
        res_init.out_delta   = c_delta[0];
      end else if (in_data_i.command == CMD_NEXT_HB) begin
        res_init.out_type  = hb_type_q;
        res_init.out_delta = (frame_q != '0) ? frame_q : DefaultFrame;
        res_init.status    = ST_HBEAT;
      end else begin
        res_init.status = ST_EMPTY;
      end
    end
  end

  always_comb begin
    res_fin             = res_q;
    res_fin.occupancy   = 5'(count_q);
    res_fin.peak_fill   = 5'(peak_q);
    res_fin.drop_count  = drop_q;
    res_fin.empty_count = empty_q;
    res_fin.hb_count    = recov_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      peak_q      <= '0;
      cap_q       <= (DepthC < CntW'(16)) ? DepthC : CntW'(16);
      drop_q      <= '0;
      empty_q     <= '0;
      recov_q     <= '0;
      hb_type_q   <= '0;
      frame_q     <= DefaultFrame;
      res_valid_q <= 1'b0;
      pos_q       <= '0;
      remain_q    <= '0;
      carry_q     <= '0;
    end else begin
      if (res_valid_q && !out_stall_i) res_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (cfg_valid_i && cfg_ready_o) begin
            unique case (cfg_index_i)
              REG_CAPACITY: begin
                cap_q   <= (32'(cap_w) > DEPTH) ? DepthC : CntW'(cap_w);
                count_q <= '0; peak_q <= '0;
                drop_q  <= '0; empty_q <= '0; recov_q <= '0;
              end
              REG_HB_TYPE: hb_type_q <= cfg_data_i[15:0];
              REG_FRAME:   frame_q   <= cfg_data_i[30:0];
              default: ;
            endcase
          end else if (in_valid_i && !in_stall_o) begin
            cmd_q    <= in_data_i;
            pos_q    <= (in_data_i.command == CMD_POST && in_data_i.at_end) ? count_q : '0;
            remain_q <= in_data_i.delay;
            carry_q  <= '0;
            res_q    <= res_init;
            unique case (in_data_i.command)
              CMD_POST: begin
                if (count_q >= cap_q) begin
                  drop_q <= sat_inc(drop_q);
                  state_q <= S_DONE;
                end else begin
                  state_q <= S_WALK;
                end
              end
              CMD_NEXT, CMD_NEXT_HB: begin
                state_q <= S_DONE;
                if (count_q != '0) begin
                  count_q <= count_q - CntW'(1);
                end else begin
                  empty_q <= sat_inc(empty_q);
                  if (in_data_i.command == CMD_NEXT_HB) begin
                    recov_q <= sat_inc(recov_q);
                  end
                end
              end
              CMD_FLUSH: begin
                count_q <= '0;
                state_q <= S_DONE;
              end
              CMD_FLUSH_TY: state_q <= S_FWALK;
              default: state_q <= S_DONE;
            endcase
          end
        end
        S_WALK: begin
          if (walk_stop) begin
            state_q <= S_INSERT;
          end else begin
            remain_q <= remain_q - c_delta[pos_q[IdxW-1:0]];
            pos_q    <= pos_q + CntW'(1);
          end
        end
        S_INSERT: begin
          count_q <= count_q + CntW'(1);
          if (count_q + CntW'(1) > peak_q) peak_q <= count_q + CntW'(1);
          state_q <= S_DONE;
        end
        S_FWALK: begin
          if (pos_q >= count_q) begin
            state_q <= S_DONE;
          end else if (flush_drop) begin
            count_q <= count_q - CntW'(1);
          end else begin
            pos_q <= pos_q + CntW'(1);
          end
        end
        S_DONE: begin
          res_q       <= res_fin;
          res_valid_q <= 1'b1;
          state_q     <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_count_le_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DepthC) else $error("fill count above depth");
  a_peak_ge_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> peak_q >= count_q || count_q == '0) else $error("peak below count");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |-> in_stall_o) else $error("accept while busy");

endmodule

@@ verif/delta_time_event_queue_top_tb.sv @@
// Self-checking testbench for the delta-time event queue: random and directed commands.
`timescale 1ns / 1ps

module delta_time_event_queue_top_tb;
  import dteq_pkg::*;

  localparam int unsigned QDEPTH = 16;
  localparam int unsigned LIMIT_CYCLES = 400000;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  in_beat_t   in_data_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  out_beat_t  out_data_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [1:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  delta_time_event_queue_top u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state: mirror of the slot chain, statistics and registers.
  logic signed [15:0] slot_type [QDEPTH];
  logic [31:0]        slot_payload [QDEPTH];
  logic [30:0]        slot_delta [QDEPTH];
  int unsigned        fill, peak;
  logic [31:0]        drops, empties, recoveries;
  int unsigned        cap_reg;
  logic signed [15:0] hb_type_reg;
  logic [30:0]        frame_reg;

  in_beat_t  pending_cmds [$];   // beats waiting for the driver
  out_beat_t expected_results [$];
  int unsigned errors = 0;
  int unsigned results_seen = 0;
  int unsigned drop_hits = 0, hb_hits = 0, full_hits = 0;
  int unsigned cycle_count = 0;

  // Idle/stall controls, set by the stimulus process.
  bit quiet_mode = 1'b0;     // no idling on either side
  bit hold_off = 1'b0;       // receiver stalls solid

  function automatic logic [31:0] sat_up(logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic void clear_queue();
    fill = 0; peak = 0; drops = '0; empties = '0; recoveries = '0;
  endfunction

  function automatic void apply_reg(reg_e idx, logic [31:0] val);
    case (idx)
      REG_CAPACITY: begin
        cap_reg = (val[4:0] > QDEPTH) ? QDEPTH : val[4:0];
        clear_queue();
      end
      REG_HB_TYPE: hb_type_reg = val[15:0];
      REG_FRAME:   frame_reg = val[30:0];
      default: ;
    endcase
  endfunction

  // Compute the result of one command and update the mirrored queue.
  function automatic out_beat_t queue_step(in_beat_t b);
    out_beat_t r;
    int unsigned pos, wr;
    logic [30:0] remaining;
    logic [31:0] carry;
    logic [31:0] sum;
    r = '0;
    case (b.command)
      CMD_POST: begin
        if (fill >= cap_reg) begin
          drops = sat_up(drops);
          r.status = ST_DROPPED;
          drop_hits++;
        end else begin
          remaining = b.delay;
          pos = 0;
          while (pos < fill) begin
            if (!b.at_end && remaining < slot_delta[pos]) break;
            if (!b.at_end) remaining -= slot_delta[pos];
            pos++;
          end
          for (int i = fill; i > pos; i--) begin
            slot_type[i] = slot_type[i-1];
            slot_payload[i] = slot_payload[i-1];
            slot_delta[i] = slot_delta[i-1];
          end
          slot_type[pos] = b.event_type;
          slot_payload[pos] = b.event_payload;
          slot_delta[pos] = b.at_end ? 31'd0 : remaining;
          if (pos + 1 <= fill) slot_delta[pos+1] -= remaining;
          fill++;
          if (fill > peak) peak = fill;
          if (fill == QDEPTH) full_hits++;
        end
      end
      CMD_NEXT, CMD_NEXT_HB: begin
        if (fill > 0) begin
          r.out_type = slot_type[0];
          r.out_payload = slot_payload[0];
          r.out_delta = slot_delta[0];
          for (int i = 1; i < fill; i++) begin
            slot_type[i-1] = slot_type[i];
            slot_payload[i-1] = slot_payload[i];
            slot_delta[i-1] = slot_delta[i];
          end
          fill--;
        end else begin
          empties = sat_up(empties);
          if (b.command == CMD_NEXT_HB) begin
            recoveries = sat_up(recoveries);
            r.out_type = hb_type_reg;
            r.out_delta = (frame_reg != 0) ? frame_reg : DefaultFrame;
            r.status = ST_HBEAT;
            hb_hits++;
          end else begin
            r.status = ST_EMPTY;
          end
        end
      end
      CMD_FLUSH: fill = 0;
      CMD_FLUSH_TY: begin
        // removed deltas fold into the next survivor, saturating at 2^31-1
        wr = 0; carry = '0;
        for (int rd = 0; rd < fill; rd++) begin
          sum = {1'b0, slot_delta[rd]} + carry;
          if (sum > {1'b0, DeltaMax}) sum = {1'b0, DeltaMax};
          if (slot_type[rd] == b.event_type) begin
            carry = sum;
          end else begin
            slot_type[wr] = slot_type[rd];
            slot_payload[wr] = slot_payload[rd];
            slot_delta[wr] = sum[30:0];
            carry = '0;
            wr++;
          end
        end
        fill = wr;
      end
      default: ;
    endcase
    r.occupancy = fill[4:0];
    r.peak_fill = peak[4:0];
    r.drop_count = drops;
    r.empty_count = empties;
    r.hb_count = recoveries;
    return r;
  endfunction

  // Driver: offers queued beats; holds the payload while stalled.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        expected_results.push_back(queue_step(in_data_i));
        void'(pending_cmds.pop_front());
      end
      if (!in_valid_i || !in_stall_o) begin
        // take the next beat (queue head after any pop above)
        if (pending_cmds.size() > 0 && (quiet_mode || $urandom_range(99) >= 35)) begin
          in_valid_i <= 1'b1;
          in_data_i <= pending_cmds[0];
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares every accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    out_beat_t want;
    cycle_count++;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result beat %h", $time, out_data_o);
        end else begin
          want = expected_results.pop_front();
          if (out_data_o !== want) begin
            errors++;
            $display("%0t: mismatch expected %h actual %h", $time, want, out_data_o);
            if (out_data_o.out_type !== want.out_type)
              $display("  out_type exp %0d act %0d", want.out_type, out_data_o.out_type);
            if (out_data_o.out_payload !== want.out_payload)
              $display("  out_payload exp %h act %h", want.out_payload, out_data_o.out_payload);
            if (out_data_o.out_delta !== want.out_delta)
              $display("  out_delta exp %0d act %0d", want.out_delta, out_data_o.out_delta);
            if (out_data_o.status !== want.status)
              $display("  status exp %0d act %0d", want.status, out_data_o.status);
            if (out_data_o.occupancy !== want.occupancy)
              $display("  occupancy exp %0d act %0d", want.occupancy, out_data_o.occupancy);
            if (out_data_o.peak_fill !== want.peak_fill)
              $display("  peak_fill exp %0d act %0d", want.peak_fill, out_data_o.peak_fill);
            if (out_data_o.drop_count !== want.drop_count)
              $display("  dropped exp %0d act %0d", want.drop_count, out_data_o.drop_count);
            if (out_data_o.empty_count !== want.empty_count)
              $display("  empty_count exp %0d act %0d", want.empty_count, out_data_o.empty_count);
            if (out_data_o.hb_count !== want.hb_count)
              $display("  hb_count exp %0d act %0d", want.hb_count, out_data_o.hb_count);
          end
        end
      end
      out_stall_i <= hold_off || (!quiet_mode && $urandom_range(99) < 35);
    end
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Register write; only called while the block is idle.
  task automatic write_reg(reg_e idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_reg(idx, val);
    cfg_valid_i <= 1'b0;
  endtask

  // Wait until every beat is sent and every result back, plus the walk latency.
  task automatic drain();
    while (pending_cmds.size() > 0 || expected_results.size() > 0) @(posedge clk_i);
    repeat (QDEPTH + 8) @(posedge clk_i);
  endtask

  function automatic in_beat_t make_beat(cmd_e c, logic signed [15:0] t, logic [31:0] p,
                                         logic [30:0] d, logic e);
    in_beat_t b;
    b.command = c; b.event_type = t; b.event_payload = p; b.delay = d; b.at_end = e;
    return b;
  endfunction

  // Mostly small type pool so flush-by-type finds matches; occasional full range.
  function automatic logic signed [15:0] pick_type();
    return ($urandom_range(9) == 0) ? 16'($urandom) : 16'(int'($urandom_range(3)) - 1);
  endfunction

  function automatic logic [30:0] pick_delay();
    case ($urandom_range(9))
      0: return DeltaMax;
      1: return 31'($urandom);
      2: return 31'd0;
      default: return 31'($urandom_range(2000));
    endcase
  endfunction

  function automatic in_beat_t rand_beat();
    int unsigned k;
    k = $urandom_range(99);
    if (k < 45) return make_beat(CMD_POST, pick_type(), $urandom, pick_delay(),
                                 $urandom_range(4) == 0);
    if (k < 65) return make_beat(CMD_NEXT, pick_type(), $urandom, 31'($urandom), 1'($urandom));
    if (k < 83) return make_beat(CMD_NEXT_HB, pick_type(), $urandom, 31'($urandom),
                                 1'($urandom));
    if (k < 88) return make_beat(CMD_FLUSH, pick_type(), $urandom, 31'($urandom),
                                 1'($urandom));
    if (k < 97) return make_beat(CMD_FLUSH_TY, pick_type(), $urandom, 31'($urandom),
                                 1'($urandom));
    // undefined command codes leave the queue alone
    return make_beat(cmd_e'(3'($urandom_range(7, 5))), 16'($urandom), $urandom,
                     31'($urandom), 1'($urandom));
  endfunction

  initial begin
    cap_reg = QDEPTH; hb_type_reg = '0; frame_reg = DefaultFrame;
    clear_queue();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (QDEPTH + 4) @(posedge clk_i);

    // Directed: empty pops, heartbeat, extremes, sorted insert, fold up to the delta maximum.
    write_reg(REG_HB_TYPE, 32'h0000_8000);
    write_reg(REG_FRAME, 32'd0);
    pending_cmds.push_back(make_beat(CMD_NEXT, '0, '0, '0, 1'b0));
    pending_cmds.push_back(make_beat(CMD_NEXT_HB, '0, '0, '0, 1'b0));
    pending_cmds.push_back(make_beat(CMD_POST, 16'sh7FFF, 32'hFFFF_FFFF, DeltaMax, 1'b0));
    pending_cmds.push_back(make_beat(CMD_POST, 16'sh8000, 32'h0, 31'd0, 1'b0));
    pending_cmds.push_back(make_beat(CMD_POST, 16'sd5, 32'h1234_5678, 31'd100, 1'b0));
    pending_cmds.push_back(make_beat(CMD_POST, 16'sd6, 32'hA5A5_5A5A, 31'd50, 1'b1));
    pending_cmds.push_back(make_beat(CMD_POST, 16'sd5, 32'h5A5A_A5A5, DeltaMax, 1'b0));
    pending_cmds.push_back(make_beat(CMD_FLUSH_TY, 16'sd6, '0, '0, 1'b0));
    pending_cmds.push_back(make_beat(CMD_FLUSH_TY, 16'sd5, '0, '0, 1'b0));
    pending_cmds.push_back(make_beat(CMD_NEXT, '0, '0, '0, 1'b0));
    pending_cmds.push_back(make_beat(CMD_NEXT_HB, '0, '0, '0, 1'b0));
    pending_cmds.push_back(make_beat(cmd_e'(3'd7), 16'hFFFF, 32'hFFFF_FFFF, DeltaMax, 1'b1));
    pending_cmds.push_back(make_beat(CMD_FLUSH, '0, '0, '0, 1'b0));
    pending_cmds.push_back(make_beat(CMD_NEXT_HB, '0, '0, '0, 1'b0));
    drain();

    // Zero capacity drops every post; oversize capacity clamps to the depth.
    write_reg(REG_CAPACITY, 32'd0);
    write_reg(REG_FRAME, 32'h7FFF_FFFF);
    write_reg(REG_HB_TYPE, 32'h0000_7FFF);
    pending_cmds.push_back(make_beat(CMD_POST, 16'sd1, 32'h1, 31'd1, 1'b0));
    pending_cmds.push_back(make_beat(CMD_NEXT_HB, '0, '0, '0, 1'b0));
    drain();
    write_reg(REG_CAPACITY, 32'hFFFF_FFFF);
    for (int i = 0; i < QDEPTH + 2; i++)
      pending_cmds.push_back(make_beat(CMD_POST, pick_type(), $urandom, pick_delay(), 1'b0));
    drain();

    // Random phases across several settings; one phase runs with no idling.
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: write_reg(REG_CAPACITY, 32'd16);
        1: write_reg(REG_CAPACITY, 32'd1);
        2: write_reg(REG_CAPACITY, 32'($urandom_range(2, 15)));
        3: write_reg(REG_CAPACITY, 32'd17);
        default: write_reg(REG_CAPACITY, 32'($urandom_range(0, 31)));
      endcase
      write_reg(REG_HB_TYPE, $urandom);
      write_reg(REG_FRAME, (ph == 1) ? 32'd1 : $urandom);
      quiet_mode = (ph == 2);
      for (int n = 0; n < 100; n++) pending_cmds.push_back(rand_beat());
      if (ph == 3) begin
        // receiver holds off while the sender keeps offering beats
        hold_off = 1'b1;
        repeat (300) @(posedge clk_i);
        hold_off = 1'b0;
      end
      drain();
    end
    quiet_mode = 1'b0;

    $display("covered %0d results: %0d drops, %0d heartbeats, %0d full-queue fills",
             results_seen, drop_hits, hb_hits, full_hits);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

@@ delta_time_event_queue_top.f @@
rtl/core/dteq_pkg.sv
rtl/core/dteq_cell.sv
rtl/core/delta_time_event_queue_top.sv
verif/delta_time_event_queue_top_tb.sv
